// File: rtl/core/cltok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cltok_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int MAX_RECS        = 5;
    localparam int NUM_KW          = 11;

    // Record kinds
    localparam logic [1:0] RK_TEXT  = 2'd0;
    localparam logic [1:0] RK_TOKEN = 2'd1;
    localparam logic [1:0] RK_ERROR = 2'd2;

    // Error codes
    localparam logic ERR_UNEXPECTED   = 1'b0;
    localparam logic ERR_UNTERMINATED = 1'b1;

    // Token kinds
    localparam logic [5:0] TK_IDENT      = 6'd0;
    localparam logic [5:0] TK_NUMBER     = 6'd11;
    localparam logic [5:0] TK_STRING     = 6'd12;
    localparam logic [5:0] TK_LBRACKET   = 6'd13;
    localparam logic [5:0] TK_RBRACKET   = 6'd14;
    localparam logic [5:0] TK_LBRACE     = 6'd15;
    localparam logic [5:0] TK_RBRACE     = 6'd16;
    localparam logic [5:0] TK_LPAREN     = 6'd17;
    localparam logic [5:0] TK_RPAREN     = 6'd18;
    localparam logic [5:0] TK_COMMA      = 6'd19;
    localparam logic [5:0] TK_SEMI       = 6'd20;
    localparam logic [5:0] TK_COLON      = 6'd21;
    localparam logic [5:0] TK_EQUAL      = 6'd22;
    localparam logic [5:0] TK_DOT        = 6'd23;
    localparam logic [5:0] TK_ARROW      = 6'd24;
    localparam logic [5:0] TK_MINUS      = 6'd25;
    localparam logic [5:0] TK_PLUS       = 6'd26;
    localparam logic [5:0] TK_STAR       = 6'd27;
    localparam logic [5:0] TK_SLASH      = 6'd28;
    localparam logic [5:0] TK_BANG       = 6'd29;
    localparam logic [5:0] TK_BANG_EQ    = 6'd30;
    localparam logic [5:0] TK_LESS       = 6'd31;
    localparam logic [5:0] TK_LESS_EQ    = 6'd32;
    localparam logic [5:0] TK_GREATER    = 6'd33;
    localparam logic [5:0] TK_GREATER_EQ = 6'd34;
    localparam logic [5:0] TK_EOF        = 6'd35;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  text;
        logic [5:0]  tok;
        logic [15:0] line;
        logic [15:0] col;
        logic        err;
    } t_rec;

    // All records caused by one accepted item
    typedef struct packed {
        logic [2:0]               count;
        t_rec [MAX_RECS-1:0]      recs;
    } t_bundle;

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        case (k)
            4'd0:    kw_len = 4'd13;
            4'd1:    kw_len = 4'd4;
            4'd2:    kw_len = 4'd8;
            4'd3:    kw_len = 4'd6;
            4'd4:    kw_len = 4'd6;
            4'd5:    kw_len = 4'd4;
            4'd6:    kw_len = 4'd5;
            4'd7:    kw_len = 4'd4;
            4'd8:    kw_len = 4'd6;
            4'd9:    kw_len = 4'd8;
            4'd10:   kw_len = 4'd4;
            default: kw_len = 4'd0;
        endcase
    endfunction

    function automatic logic [5:0] kw_kind(input logic [3:0] k);
        case (k)
            4'd0:    kw_kind = 6'd1;
            4'd1:    kw_kind = 6'd2;
            4'd2:    kw_kind = 6'd3;
            4'd3:    kw_kind = 6'd4;
            4'd4:    kw_kind = 6'd5;
            4'd5:    kw_kind = 6'd6;
            4'd6:    kw_kind = 6'd6;
            4'd7:    kw_kind = 6'd7;
            4'd8:    kw_kind = 6'd8;
            4'd9:    kw_kind = 6'd9;
            4'd10:   kw_kind = 6'd10;
            default: kw_kind = TK_IDENT;
        endcase
    endfunction

    // Character at position i of keyword k; only meaningful for i below its length.
    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] i);
        logic [127:0] w;
        logic [3:0]   sh;
        case (k)
            4'd0:    w = 128'("Configuration");
            4'd1:    w = 128'("Name");
            4'd2:    w = 128'("Template");
            4'd3:    w = 128'("Custom");
            4'd4:    w = 128'("Import");
            4'd5:    w = 128'("true");
            4'd6:    w = 128'("false");
            4'd7:    w = 128'("null");
            4'd8:    w = 128'("@Style");
            4'd9:    w = 128'("@Element");
            4'd10:   w = 128'("@Var");
            default: w = '0;
        endcase
        sh = (i < kw_len(k)) ? (kw_len(k) - 4'd1 - i) : 4'd0;
        kw_char = w[{sh, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/cltok_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cltok_front #(
    parameter int LINE_BITS   = cltok_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = cltok_pkg::COLUMN_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic              i_has_byte,
    input  wire logic [7:0]        i_source_byte,
    input  wire logic              i_end_of_text,
    output cltok_pkg::t_bundle     o_bundle
);
    import cltok_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_STRING, M_STR_ESC,
        M_SLASH, M_LINE_CMT, M_BLOCK_CMT, M_BLOCK_STAR, M_MINUS, M_BANG,
        M_LESS, M_GREATER, M_ERROR
    } t_mode;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

    t_mode                  r_mode, n_mode;
    logic                   r_quote, n_quote;
    logic [NUM_KW-1:0]      r_mask, n_mask;
    logic [3:0]             r_len, n_len;
    logic [LINE_BITS-1:0]   r_line, n_line, r_tsl, n_tsl;
    logic [COLUMN_BITS-1:0] r_col, n_col, r_tsc, n_tsc, r_dot, n_dot;

    function automatic t_rec mk(input logic [1:0] kind, input logic [7:0] text,
                                input logic [5:0] tok, input logic [15:0] line,
                                input logic [15:0] col, input logic err);
        t_rec r;
        r.kind = kind;
        r.text = text;
        r.tok  = tok;
        r.line = line;
        r.col  = col;
        r.err  = err;
        return r;
    endfunction

    // Next state and the records of one item, in model order
    always_comb begin
        logic [7:0]        ch;
        logic              is_sp, is_al, is_dg, do_idle, do_add, err_end;
        logic [5:0]        op, ik;
        t_rec [MAX_RECS-1:0] recs;
        logic [2:0]        cnt;

        n_mode  = r_mode;
        n_quote = r_quote;
        n_mask  = r_mask;
        n_len   = r_len;
        n_line  = r_line;
        n_col   = r_col;
        n_tsl   = r_tsl;
        n_tsc   = r_tsc;
        n_dot   = r_dot;
        recs    = '0;
        cnt     = '0;
        do_idle = 1'b0;
        do_add  = 1'b0;
        err_end = 1'b0;
        ch      = i_source_byte;
        is_sp   = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
        is_al   = (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
        is_dg   = (ch >= "0" && ch <= "9");
        ik      = TK_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (r_mask[k] && kw_len(4'(k)) == r_len) ik = kw_kind(4'(k));
        end
        case (ch)
            "[":     op = TK_LBRACKET;
            "]":     op = TK_RBRACKET;
            "{":     op = TK_LBRACE;
            "}":     op = TK_RBRACE;
            "(":     op = TK_LPAREN;
            ")":     op = TK_RPAREN;
            ",":     op = TK_COMMA;
            ";":     op = TK_SEMI;
            ":":     op = TK_COLON;
            "=":     op = TK_EQUAL;
            ".":     op = TK_DOT;
            "+":     op = TK_PLUS;
            "*":     op = TK_STAR;
            default: op = TK_IDENT;
        endcase

        if (i_has_byte) begin
            // Handle the byte in the current mode
            unique case (r_mode)
                M_IDLE: do_idle = 1'b1;
                M_IDENT: begin
                    if (is_al || is_dg || ch == "_") begin
                        do_add = 1'b1;
                    end else begin
                        recs[cnt] = mk(RK_TOKEN, 8'd0, ik, 16'(r_tsl), 16'(r_tsc), 1'b0);
                        cnt = cnt + 3'd1;
                        n_mode  = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_NUM_INT, M_NUM_FRAC: begin
                    if (is_dg) begin
                        recs[cnt] = mk(RK_TEXT, ch, 6'd0, 16'(r_tsl), 16'(r_tsc), 1'b0);
                        cnt = cnt + 3'd1;
                    end else if (r_mode == M_NUM_INT && ch == ".") begin
                        n_dot  = r_col;
                        n_mode = M_NUM_DOT;
                    end else begin
                        recs[cnt] = mk(RK_TOKEN, 8'd0, TK_NUMBER, 16'(r_tsl), 16'(r_tsc),
                                       1'b0);
                        cnt = cnt + 3'd1;
                        n_mode  = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_NUM_DOT: begin
                    if (is_dg) begin
                        recs[cnt] = mk(RK_TEXT, ".", 6'd0, 16'(r_tsl), 16'(r_tsc), 1'b0);
                        cnt = cnt + 3'd1;
                        recs[cnt] = mk(RK_TEXT, ch, 6'd0, 16'(r_tsl), 16'(r_tsc), 1'b0);
                        cnt = cnt + 3'd1;
                        n_mode = M_NUM_FRAC;
                    end else begin
                        recs[cnt] = mk(RK_TOKEN, 8'd0, TK_NUMBER, 16'(r_tsl), 16'(r_tsc),
                                       1'b0);
                        cnt = cnt + 3'd1;
                        recs[cnt] = mk(RK_TOKEN, 8'd0, TK_DOT, 16'(r_line), 16'(r_dot), 1'b0);
                        cnt = cnt + 3'd1;
                        n_mode  = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_STRING: begin
                    if (ch == (r_quote ? 8'h27 : 8'h22)) begin
                        recs[cnt] = mk(RK_TOKEN, 8'd0, TK_STRING, 16'(r_tsl), 16'(r_tsc),
                                       1'b0);
                        cnt = cnt + 3'd1;
                        n_mode = M_IDLE;
                    end else if (ch == 8'h5c) begin
                        n_mode = M_STR_ESC;
                    end else begin
                        recs[cnt] = mk(RK_TEXT, ch, 6'd0, 16'(r_tsl), 16'(r_tsc), 1'b0);
                        cnt = cnt + 3'd1;
                    end
                end
                M_STR_ESC: begin
                    recs[cnt] = mk(RK_TEXT, (ch == "n") ? 8'd10 : (ch == "t") ? 8'd9 :
                                   (ch == "r") ? 8'd13 : ch,
                                   6'd0, 16'(r_tsl), 16'(r_tsc), 1'b0);
                    cnt = cnt + 3'd1;
                    n_mode = M_STRING;
                end
                M_SLASH: begin
                    if (ch == "/") begin
                        n_mode = M_LINE_CMT;
                    end else if (ch == "*") begin
                        n_mode = M_BLOCK_CMT;
                    end else begin
                        recs[cnt] = mk(RK_TOKEN, 8'd0, TK_SLASH, 16'(r_tsl), 16'(r_tsc), 1'b0);
                        cnt = cnt + 3'd1;
                        n_mode  = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_LINE_CMT: begin
                    if (ch == 8'd10) n_mode = M_IDLE;
                end
                M_BLOCK_CMT: begin
                    if (ch == "*") n_mode = M_BLOCK_STAR;
                end
                M_BLOCK_STAR: begin
                    if (ch == "/") n_mode = M_IDLE;
                    else if (ch != "*") n_mode = M_BLOCK_CMT;
                end
                M_MINUS, M_BANG, M_LESS, M_GREATER: begin
                    n_mode = M_IDLE;
                    if (r_mode == M_MINUS && ch == ">") begin
                        recs[cnt] = mk(RK_TOKEN, 8'd0, TK_ARROW, 16'(r_tsl), 16'(r_tsc), 1'b0);
                    end else if (r_mode != M_MINUS && ch == "=") begin
                        recs[cnt] = mk(RK_TOKEN, 8'd0,
                                       (r_mode == M_BANG) ? TK_BANG_EQ :
                                       (r_mode == M_LESS) ? TK_LESS_EQ : TK_GREATER_EQ,
                                       16'(r_tsl), 16'(r_tsc), 1'b0);
                    end else begin
                        recs[cnt] = mk(RK_TOKEN, 8'd0,
                                       (r_mode == M_MINUS) ? TK_MINUS :
                                       (r_mode == M_BANG) ? TK_BANG :
                                       (r_mode == M_LESS) ? TK_LESS : TK_GREATER,
                                       16'(r_tsl), 16'(r_tsc), 1'b0);
                        do_idle = 1'b1;
                    end
                    cnt = cnt + 3'd1;
                end
                M_ERROR: ;
                default: ;
            endcase

            // Start of a new token from the between-tokens state
            if (do_idle && !is_sp) begin
                n_tsl = r_line;
                n_tsc = r_col;
                if (is_al || ch == "_" || ch == "@") begin
                    n_mode = M_IDENT;
                    n_mask = '1;
                    n_len  = '0;
                    do_add = 1'b1;
                end else if (is_dg) begin
                    n_mode = M_NUM_INT;
                    recs[cnt] = mk(RK_TEXT, ch, 6'd0, 16'(r_line), 16'(r_col), 1'b0);
                    cnt = cnt + 3'd1;
                end else if (ch == 8'h22 || ch == 8'h27) begin
                    n_mode  = M_STRING;
                    n_quote = (ch == 8'h27);
                end else if (ch == "/") begin
                    n_mode = M_SLASH;
                end else if (ch == "-") begin
                    n_mode = M_MINUS;
                end else if (ch == "!") begin
                    n_mode = M_BANG;
                end else if (ch == "<") begin
                    n_mode = M_LESS;
                end else if (ch == ">") begin
                    n_mode = M_GREATER;
                end else if (op != TK_IDENT) begin
                    recs[cnt] = mk(RK_TOKEN, 8'd0, op, 16'(r_line), 16'(r_col), 1'b0);
                    cnt = cnt + 3'd1;
                end else begin
                    recs[cnt] = mk(RK_ERROR, 8'd0, 6'd0, 16'(r_line), 16'(r_col),
                                   ERR_UNEXPECTED);
                    cnt = cnt + 3'd1;
                    n_mode = M_ERROR;
                end
            end

            // Identifier character: narrow the keyword candidates
            if (do_add) begin
                for (int k = 0; k < NUM_KW; k++) begin
                    if (!(n_len < kw_len(4'(k)) && kw_char(4'(k), n_len) == ch))
                        n_mask[k] = 1'b0;
                end
                recs[cnt] = mk(RK_TEXT, ch, 6'd0, 16'(n_tsl), 16'(n_tsc), 1'b0);
                cnt = cnt + 3'd1;
                if (n_len != 4'd15) n_len = n_len + 4'd1;
            end

            // Saturating position update
            if (ch == 8'd10) begin
                if (r_line != LINE_MAX) n_line = r_line + LINE_ONE;
                n_col = COL_ONE;
            end else if (r_col != COL_MAX) begin
                n_col = r_col + COL_ONE;
            end
        end

        // End of text: flush the pending token, then EOF unless an error ended the text
        if (i_end_of_text) begin
            ik = TK_IDENT;
            for (int k = NUM_KW - 1; k >= 0; k--) begin
                if (n_mask[k] && kw_len(4'(k)) == n_len) ik = kw_kind(4'(k));
            end
            unique case (n_mode)
                M_IDENT: begin
                    recs[cnt] = mk(RK_TOKEN, 8'd0, ik, 16'(n_tsl), 16'(n_tsc), 1'b0);
                    cnt = cnt + 3'd1;
                end
                M_NUM_INT, M_NUM_FRAC: begin
                    recs[cnt] = mk(RK_TOKEN, 8'd0, TK_NUMBER, 16'(n_tsl), 16'(n_tsc), 1'b0);
                    cnt = cnt + 3'd1;
                end
                M_NUM_DOT: begin
                    recs[cnt] = mk(RK_TOKEN, 8'd0, TK_NUMBER, 16'(n_tsl), 16'(n_tsc), 1'b0);
                    cnt = cnt + 3'd1;
                    recs[cnt] = mk(RK_TOKEN, 8'd0, TK_DOT, 16'(n_line), 16'(n_dot), 1'b0);
                    cnt = cnt + 3'd1;
                end
                M_STRING, M_STR_ESC: begin
                    recs[cnt] = mk(RK_ERROR, 8'd0, 6'd0, 16'(n_tsl), 16'(n_tsc),
                                   ERR_UNTERMINATED);
                    cnt = cnt + 3'd1;
                    err_end = 1'b1;
                end
                M_SLASH, M_MINUS, M_BANG, M_LESS, M_GREATER: begin
                    recs[cnt] = mk(RK_TOKEN, 8'd0,
                                   (n_mode == M_SLASH) ? TK_SLASH :
                                   (n_mode == M_MINUS) ? TK_MINUS :
                                   (n_mode == M_BANG) ? TK_BANG :
                                   (n_mode == M_LESS) ? TK_LESS : TK_GREATER,
                                   16'(n_tsl), 16'(n_tsc), 1'b0);
                    cnt = cnt + 3'd1;
                end
                M_ERROR: err_end = 1'b1;
                default: ;
            endcase
            if (!err_end) begin
                recs[cnt] = mk(RK_TOKEN, 8'd0, TK_EOF, 16'(n_line), 16'(n_col), 1'b0);
                cnt = cnt + 3'd1;
            end
            n_mode  = M_IDLE;
            n_quote = 1'b0;
            n_mask  = '1;
            n_len   = '0;
            n_line  = LINE_ONE;
            n_col   = COL_ONE;
            n_tsl   = LINE_ONE;
            n_tsc   = COL_ONE;
            n_dot   = COL_ONE;
        end

        o_bundle.count = cnt;
        o_bundle.recs  = recs;
    end

    // Lexer state, advanced on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_quote <= 1'b0;
            r_mask  <= '1;
            r_len   <= '0;
            r_line  <= LINE_ONE;
            r_col   <= COL_ONE;
            r_tsl   <= LINE_ONE;
            r_tsc   <= COL_ONE;
            r_dot   <= COL_ONE;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_quote <= n_quote;
            r_mask  <= n_mask;
            r_len   <= n_len;
            r_line  <= n_line;
            r_col   <= n_col;
            r_tsl   <= n_tsl;
            r_tsc   <= n_tsc;
            r_dot   <= n_dot;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/cltok_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cltok_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  cltok_pkg::t_bundle     i_bundle,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output cltok_pkg::t_rec        o_rec,
    output logic                   o_last
);
    import cltok_pkg::*;

    t_bundle    r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [2:0] r_idx;
    logic       pop_rec, pop_entry;

    assign o_full    = (r_cnt == 2'd2);
    assign o_valid   = (r_cnt != 2'd0);
    assign o_rec     = r_q[r_rp].recs[r_idx];
    assign o_last    = (r_idx == r_q[r_rp].count - 3'd1);
    assign pop_rec   = o_valid && i_ready;
    assign pop_entry = pop_rec && o_last;

    // Bundle storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_bundle;
    end

    // Queue pointers and the record index within the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_idx <= 3'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop_entry) begin
                r_rp  <= ~r_rp;
                r_idx <= 3'd0;
            end else if (pop_rec) begin
                r_idx <= r_idx + 3'd1;
            end
            if (i_push && !pop_entry) r_cnt <= r_cnt + 2'd1;
            else if (!i_push && pop_entry) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/config_language_tokenizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// input    | i_valid / o_ready    | i_has_byte, i_source_byte, i_end_of_text
// output   | o_valid / i_ready    | o_record_kind, o_text_byte, o_token_kind,
//          |                      | o_start_line, o_start_column, o_error_code,
//          |                      | o_last_of_run
//
// The lexer takes one item per cycle while o_ready is high and writes all of its
// records (zero to five) into a two-entry bundle queue. The output side sends one
// record per cycle while i_ready is high. o_ready drops while both queue entries
// are held. Reset is synchronous and active low; it clears the lexer state and
// empties the queue.
module config_language_tokenizer_unit #(
    parameter int LINE_BITS   = cltok_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = cltok_pkg::COLUMN_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_has_byte,
    input  wire logic [7:0]  i_source_byte,
    input  wire logic        i_end_of_text,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_record_kind,
    output logic [7:0]       o_text_byte,
    output logic [5:0]       o_token_kind,
    output logic [15:0]      o_start_line,
    output logic [15:0]      o_start_column,
    output logic             o_error_code,
    output logic             o_last_of_run
);
    import cltok_pkg::*;

    t_bundle bundle;
    t_rec    rec;
    logic    full, accept;

    assign o_ready = !full;
    assign accept  = i_valid && !full;

    cltok_front #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_has_byte    (i_has_byte),
        .i_source_byte (i_source_byte),
        .i_end_of_text (i_end_of_text),
        .o_bundle      (bundle)
    );

    cltok_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept && bundle.count != 3'd0),
        .i_bundle (bundle),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_rec    (rec),
        .o_last   (o_last_of_run)
    );

    // Record fields onto the ports
    assign o_record_kind  = rec.kind;
    assign o_text_byte    = rec.text;
    assign o_token_kind   = rec.tok;
    assign o_start_line   = rec.line;
    assign o_start_column = rec.col;
    assign o_error_code   = rec.err;

endmodule

`default_nettype wire

// File: sim/tb_config_language_tokenizer_unit.sv
`timescale 1ns / 1ps

module tb_config_language_tokenizer_unit;
    import cltok_pkg::*;

    // Lexer modes of the predictor
    typedef enum logic [3:0] {
        LM_IDLE, LM_IDENT, LM_NUM_INT, LM_NUM_DOT, LM_NUM_FRAC, LM_STRING, LM_STR_ESC,
        LM_SLASH, LM_LINE_CMT, LM_BLOCK_CMT, LM_BLOCK_STAR, LM_MINUS, LM_BANG, LM_LESS,
        LM_GREATER, LM_ERROR
    } t_lex_mode;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] source_byte;
        logic       end_of_text;
    } t_src_item;

    typedef struct packed {
        t_rec rec;
        logic last;
    } t_expected_rec;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [15:0] POS_MAX = 16'hFFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        src_valid = 1'b0;
    logic        src_ready;
    logic        has_byte = 1'b0;
    logic [7:0]  source_byte = 8'd0;
    logic        end_of_text = 1'b0;
    logic        rec_valid;
    logic        rec_ready = 1'b0;
    logic [1:0]  rec_kind;
    logic [7:0]  rec_text;
    logic [5:0]  rec_tok;
    logic [15:0] rec_line;
    logic [15:0] rec_col;
    logic        rec_err;
    logic        rec_last;

    t_src_item     pending_items[$];
    t_expected_rec expected_recs[$];
    int            mismatches = 0;
    int            cycles = 0;
    bit            stimulus_done = 1'b0;
    bit            hold_sender = 1'b0;
    bit            no_idle = 1'b0;

    // Predictor state
    t_lex_mode   p_mode;
    logic        p_single_quote;
    logic [10:0] p_kw_mask;
    logic [3:0]  p_id_len;
    logic [15:0] p_line, p_col, p_tok_line, p_tok_col, p_dot_col;
    int          p_count;

    config_language_tokenizer_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(src_valid), .o_ready(src_ready),
        .i_has_byte(has_byte), .i_source_byte(source_byte), .i_end_of_text(end_of_text),
        .o_valid(rec_valid), .i_ready(rec_ready), .o_record_kind(rec_kind),
        .o_text_byte(rec_text), .o_token_kind(rec_tok), .o_start_line(rec_line),
        .o_start_column(rec_col), .o_error_code(rec_err), .o_last_of_run(rec_last)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic string keyword_text(int k);
        case (k)
            0: return "Configuration";
            1: return "Name";
            2: return "Template";
            3: return "Custom";
            4: return "Import";
            5: return "true";
            6: return "false";
            7: return "null";
            8: return "@Style";
            9: return "@Element";
            default: return "@Var";
        endcase
    endfunction

    function automatic logic [5:0] keyword_token(int k);
        logic [5:0] kinds[11] = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd6, 6'd7, 6'd8,
                                  6'd9, 6'd10};
        return kinds[k];
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] single_char_op(logic [7:0] c);
        case (c)
            "[": return TK_LBRACKET;
            "]": return TK_RBRACKET;
            "{": return TK_LBRACE;
            "}": return TK_RBRACE;
            "(": return TK_LPAREN;
            ")": return TK_RPAREN;
            ",": return TK_COMMA;
            ";": return TK_SEMI;
            ":": return TK_COLON;
            "=": return TK_EQUAL;
            ".": return TK_DOT;
            "+": return TK_PLUS;
            "*": return TK_STAR;
            default: return TK_IDENT;
        endcase
    endfunction

    task automatic push_rec(logic [1:0] kind, logic [7:0] text, logic [5:0] tok,
                            logic [15:0] line, logic [15:0] col, logic err);
        t_expected_rec e;
        if (p_count >= MAX_RECS) return;
        e.rec = '{kind: kind, text: text, tok: tok, line: line, col: col, err: err};
        e.last = 1'b0;
        expected_recs = {expected_recs, e};
        p_count++;
    endtask

    task automatic push_text(logic [7:0] c);
        push_rec(RK_TEXT, c, TK_IDENT, p_tok_line, p_tok_col, 1'b0);
    endtask

    task automatic push_token(logic [5:0] tok);
        push_rec(RK_TOKEN, 8'd0, tok, p_tok_line, p_tok_col, 1'b0);
    endtask

    task automatic clear_lexer();
        p_mode = LM_IDLE;
        p_single_quote = 1'b0;
        p_kw_mask = '1;
        p_id_len = 4'd0;
        p_line = 16'd1;
        p_col = 16'd1;
        p_tok_line = 16'd1;
        p_tok_col = 16'd1;
        p_dot_col = 16'd1;
    endtask

    task automatic ident_char(logic [7:0] c);
        string kw;
        for (int k = 0; k < NUM_KW; k++) begin
            kw = keyword_text(k);
            if (!(p_id_len < kw.len() && kw[p_id_len] == c)) p_kw_mask[k] = 1'b0;
        end
        if (p_id_len < 4'd15) p_id_len++;
        push_text(c);
    endtask

    function automatic logic [5:0] ident_token();
        for (int k = 0; k < NUM_KW; k++) begin
            if (p_kw_mask[k] && keyword_text(k).len() == p_id_len) return keyword_token(k);
        end
        return TK_IDENT;
    endfunction

    // Start of a new token from the idle mode.
    task automatic start_token(logic [7:0] c, logic [15:0] line, logic [15:0] col);
        logic [5:0] op;
        if (is_space(c)) return;
        p_tok_line = line;
        p_tok_col = col;
        if (is_alpha(c) || c == "_" || c == "@") begin
            p_mode = LM_IDENT;
            p_kw_mask = '1;
            p_id_len = 4'd0;
            ident_char(c);
        end else if (is_digit(c)) begin
            p_mode = LM_NUM_INT;
            push_text(c);
        end else if (c == "\"" || c == "'") begin
            p_mode = LM_STRING;
            p_single_quote = (c == "'");
        end else if (c == "/") p_mode = LM_SLASH;
        else if (c == "-") p_mode = LM_MINUS;
        else if (c == "!") p_mode = LM_BANG;
        else if (c == "<") p_mode = LM_LESS;
        else if (c == ">") p_mode = LM_GREATER;
        else begin
            op = single_char_op(c);
            if (op != TK_IDENT) begin
                push_token(op);
            end else begin
                push_rec(RK_ERROR, 8'd0, TK_IDENT, line, col, ERR_UNEXPECTED);
                p_mode = LM_ERROR;
            end
        end
    endtask

    task automatic close_pair(logic [7:0] c, logic [7:0] second, logic [5:0] pair_tok,
                              logic [5:0] single_tok, logic [15:0] line, logic [15:0] col);
        p_mode = LM_IDLE;
        if (c == second) begin
            push_token(pair_tok);
        end else begin
            push_token(single_tok);
            start_token(c, line, col);
        end
    endtask

    task automatic lex_char(logic [7:0] c);
        logic [15:0] line, col;
        line = p_line;
        col = p_col;
        case (p_mode)
            LM_IDLE: start_token(c, line, col);
            LM_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    ident_char(c);
                end else begin
                    push_token(ident_token());
                    p_mode = LM_IDLE;
                    start_token(c, line, col);
                end
            end
            LM_NUM_INT: begin
                if (is_digit(c)) begin
                    push_text(c);
                end else if (c == ".") begin
                    p_dot_col = col;
                    p_mode = LM_NUM_DOT;
                end else begin
                    push_token(TK_NUMBER);
                    p_mode = LM_IDLE;
                    start_token(c, line, col);
                end
            end
            LM_NUM_DOT: begin
                if (is_digit(c)) begin
                    push_text(".");
                    push_text(c);
                    p_mode = LM_NUM_FRAC;
                end else begin
                    push_token(TK_NUMBER);
                    push_rec(RK_TOKEN, 8'd0, TK_DOT, p_line, p_dot_col, 1'b0);
                    p_mode = LM_IDLE;
                    start_token(c, line, col);
                end
            end
            LM_NUM_FRAC: begin
                if (is_digit(c)) begin
                    push_text(c);
                end else begin
                    push_token(TK_NUMBER);
                    p_mode = LM_IDLE;
                    start_token(c, line, col);
                end
            end
            LM_STRING: begin
                if (c == (p_single_quote ? 8'h27 : 8'h22)) begin
                    push_token(TK_STRING);
                    p_mode = LM_IDLE;
                end else if (c == "\\") begin
                    p_mode = LM_STR_ESC;
                end else begin
                    push_text(c);
                end
            end
            LM_STR_ESC: begin
                if (c == "n") push_text(8'h0A);
                else if (c == "t") push_text(8'h09);
                else if (c == "r") push_text(8'h0D);
                else push_text(c);
                p_mode = LM_STRING;
            end
            LM_SLASH: begin
                if (c == "/") p_mode = LM_LINE_CMT;
                else if (c == "*") p_mode = LM_BLOCK_CMT;
                else begin
                    push_token(TK_SLASH);
                    p_mode = LM_IDLE;
                    start_token(c, line, col);
                end
            end
            LM_LINE_CMT: if (c == 8'h0A) p_mode = LM_IDLE;
            LM_BLOCK_CMT: if (c == "*") p_mode = LM_BLOCK_STAR;
            LM_BLOCK_STAR: begin
                if (c == "/") p_mode = LM_IDLE;
                else if (c != "*") p_mode = LM_BLOCK_CMT;
            end
            LM_MINUS: close_pair(c, ">", TK_ARROW, TK_MINUS, line, col);
            LM_BANG: close_pair(c, "=", TK_BANG_EQ, TK_BANG, line, col);
            LM_LESS: close_pair(c, "=", TK_LESS_EQ, TK_LESS, line, col);
            LM_GREATER: close_pair(c, "=", TK_GREATER_EQ, TK_GREATER, line, col);
            default: ;
        endcase
        // Position counters saturate.
        if (c == 8'h0A) begin
            if (p_line != POS_MAX) p_line++;
            p_col = 16'd1;
        end else if (p_col != POS_MAX) begin
            p_col++;
        end
    endtask

    task automatic lex_finish();
        bit failed;
        failed = 1'b0;
        case (p_mode)
            LM_IDENT: push_token(ident_token());
            LM_NUM_INT, LM_NUM_FRAC: push_token(TK_NUMBER);
            LM_NUM_DOT: begin
                push_token(TK_NUMBER);
                push_rec(RK_TOKEN, 8'd0, TK_DOT, p_line, p_dot_col, 1'b0);
            end
            LM_STRING, LM_STR_ESC: begin
                push_rec(RK_ERROR, 8'd0, TK_IDENT, p_tok_line, p_tok_col, ERR_UNTERMINATED);
                failed = 1'b1;
            end
            LM_SLASH: push_token(TK_SLASH);
            LM_MINUS: push_token(TK_MINUS);
            LM_BANG: push_token(TK_BANG);
            LM_LESS: push_token(TK_LESS);
            LM_GREATER: push_token(TK_GREATER);
            LM_ERROR: failed = 1'b1;
            default: ;
        endcase
        if (!failed) push_rec(RK_TOKEN, 8'd0, TK_EOF, p_line, p_col, 1'b0);
    endtask

    // Expected records for one accepted item.
    task automatic predict_records(t_src_item it);
        p_count = 0;
        if (it.has_byte) lex_char(it.source_byte);
        if (it.end_of_text) begin
            lex_finish();
            clear_lexer();
        end
        if (p_count > 0) expected_recs[$].last = 1'b1;
    endtask

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Driver: one transfer per accepted item, fed from the pending queue.
    always @(posedge clk) begin
        if (rst_n) begin
            if (src_valid && src_ready) begin
                predict_records('{has_byte, source_byte, end_of_text});
                void'(pending_items.pop_front());
            end
            if ((!src_valid || src_ready) && pending_items.size() > 0 && !hold_sender &&
                (no_idle || $urandom_range(99) >= 11)) begin
                src_valid <= 1'b1;
                has_byte <= pending_items[0].has_byte;
                source_byte <= pending_items[0].source_byte;
                end_of_text <= pending_items[0].end_of_text;
            end else if (src_valid && src_ready) begin
                src_valid <= 1'b0;
            end
        end
    end

    // The head of the pending queue stays there until its transfer, so the driver
    // always presents pending_items[0] after the pop of the accepted one.

    // Monitor: check each record transfer against the oldest expectation.
    always @(posedge clk) begin
        t_expected_rec e;
        if (rst_n) begin
            if (rec_valid && rec_ready) begin
                if (expected_recs.size() == 0) begin
                    report_mismatch("record with nothing expected");
                end else begin
                    e = expected_recs.pop_front();
                    if (rec_kind != e.rec.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", rec_kind, e.rec.kind));
                    if (rec_text != e.rec.text)
                        report_mismatch($sformatf("text %h, want %h", rec_text, e.rec.text));
                    if (rec_tok != e.rec.tok)
                        report_mismatch($sformatf("token %0d, want %0d", rec_tok, e.rec.tok));
                    if (rec_line != e.rec.line)
                        report_mismatch($sformatf("line %0d, want %0d", rec_line, e.rec.line));
                    if (rec_col != e.rec.col)
                        report_mismatch($sformatf("col %0d, want %0d", rec_col, e.rec.col));
                    if (rec_err != e.rec.err)
                        report_mismatch($sformatf("error %0d, want %0d", rec_err, e.rec.err));
                    if (rec_last != e.last)
                        report_mismatch($sformatf("last %0d, want %0d", rec_last, e.last));
                end
            end
            rec_ready <= no_idle || $urandom_range(99) >= 11;
        end
    end

    // Cycle limit.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Append one item to the pending queue.
    task automatic queue_item(logic hb, logic [7:0] b, logic eot);
        t_src_item it;
        it.has_byte = hb;
        it.source_byte = b;
        it.end_of_text = eot;
        pending_items = {pending_items, it};
    endtask

    task automatic add_byte(logic [7:0] c, logic last = 1'b0);
        queue_item(1'b1, c, last);
    endtask

    task automatic add_text(string s, bit close = 1'b1);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], close && i == s.len() - 1);
    endtask

    // Random fragment of well-formed source text.
    function automatic string random_fragment();
        string ops[$] = '{"[", "]", "{", "}", "(", ")", ",", ";", ":", "=", ".", "->", "-",
                          "+", "*", "/", "!", "!=", "<", "<=", ">", ">="};
        string s;
        int n;
        case ($urandom_range(9))
            0, 1: s = keyword_text($urandom_range(10));
            2: begin
                s = "";
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(0, 3) == 0 ? "_" : "a" + $urandom_range(25)))};
            end
            3: s = $sformatf("%0d.%0d", $urandom_range(999), $urandom_range(99));
            4: s = $sformatf("%0d", $urandom_range(99999));
            5: s = $urandom_range(1) ? "\"a\\nb\\\"c\"" : "'x\\ty\\q'";
            6: s = "// note\n";
            7: s = "/* c **/";
            default: s = ops[$urandom_range(ops.size() - 1)];
        endcase
        return {s, $urandom_range(2) == 0 ? "\n" : " "};
    endfunction

    initial begin
        int sent;
        string frag;
        clear_lexer();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: keywords, operators, numbers, strings, comments, and error cases.
        add_text("Configuration Name Template Custom Import true false null @Style\n");
        add_text("@Element @Var @ _x9 [](){},;:=.->-+*/!!=<<=>>= 12.5 7.", 1'b0);
        add_text("x 3.. 'a\\n\\t\\r\\'' \"q\" //c\n/*x*/ /", 1'b1);
        add_text("\"open", 1'b1);
        add_text("'esc\\", 1'b1);
        add_text("a#b c", 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b1);
        queue_item(1'b0, 8'hA5, 1'b0);
        queue_item(1'b0, 8'h5A, 1'b1);
        add_text("/* open", 1'b1);
        add_text("- ! < > 9", 1'b1);

        // Pause the sender until every expected record has come.
        wait (pending_items.size() == 0);
        hold_sender = 1'b1;
        wait (!src_valid && expected_recs.size() == 0);
        repeat (20) @(posedge clk);
        hold_sender = 1'b0;

        // Random: mostly well-formed text, some noise, a long stretch with no idling.
        sent = 0;
        while (sent < 100) begin
            if (sent > 20 && sent < 80) no_idle = 1'b1;
            else no_idle = 1'b0;
            if ($urandom_range(9) == 0) begin
                queue_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                           1'($urandom_range(7) == 0));
                sent++;
            end else begin
                frag = random_fragment();
                add_text(frag, $urandom_range(11) == 0);
                sent += frag.len();
            end
            wait (pending_items.size() < 8);
        end
        no_idle = 1'b0;
        queue_item(1'b0, 8'h00, 1'b1);

        wait (pending_items.size() == 0 && !src_valid);
        wait (expected_recs.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_recs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/cltok_pkg.sv
rtl/core/cltok_front.sv
rtl/core/cltok_back.sv
rtl/core/config_language_tokenizer_unit.sv
sim/tb_config_language_tokenizer_unit.sv
